>>> rtl/core/lis_length_fenwick_max_macros.svh
// assertion macros shared by the lis length block
`ifndef LIS_LENGTH_FENWICK_MAX_MACROS_SVH
`define LIS_LENGTH_FENWICK_MAX_MACROS_SVH

// condition must hold on every clock outside reset
`define LFM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the clock after the antecedent
`define LFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same clock as the antecedent
`define LFM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/lfm_pkg.sv
// shared types for the lis length block: payloads, states, command and status
package lfm_pkg;

  localparam int VAL_W = 11;

  typedef struct packed {
    logic [VAL_W-1:0] rank;
    logic             last;
  } lfm_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] best_length;
    logic [VAL_W-1:0] removals;
    logic             range_error;
    logic             final_res;
  } lfm_result_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_QUERY,
    ST_UPDATE,
    ST_FINISH
  } lfm_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic q_step;
    logic u_step;
    logic finish;
    logic sweep_step;
  } lfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_rank;
    logic q_done;
    logic u_done;
    logic out_free;
    logic last_item;
    logic sweep_done;
  } lfm_status_t;

endpackage

>>> rtl/core/lfm_ram.sv
// generic simple dual-port ram with registered read
module lfm_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lfm_ctrl.sv
// sequencing state machine for query walk, update walk, result and sweep
module lfm_ctrl import lfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  lfm_status_t status,
  output lfm_cmd_t    cmd
);

  lfm_state_t state, state_next;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = status.bad_rank ? ST_FINISH : ST_QUERY;
        end
      end
      ST_QUERY: begin
        cmd.q_step = 1'b1;
        if (status.q_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.u_step = 1'b1;
        if (status.u_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = status.last_item ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

endmodule

>>> rtl/core/lfm_dp.sv
// tree walks, counters, result register and clearing sweep over the tree ram
module lfm_dp import lfm_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [VAL_W-1:0] seq_len,
  input  lfm_item_t        item,
  input  lfm_cmd_t         cmd,
  output lfm_status_t      status,
  output lfm_result_t      result,
  output logic             result_valid,
  input  logic             result_ready
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int CW = ((PW > VAL_W) ? PW : VAL_W) + 1;
  localparam logic [CW-1:0]    MAX_POS = CW'(MAX_LEN);
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  logic [CW-1:0]    size, rank_ext;
  logic [CW-1:0]    qpos, upos, hw, sp;
  logic [CW-1:0]    q_low, u_low;
  logic             qpend, upend;
  logic [AW-1:0]    upend_addr;
  logic [VAL_W-1:0] m, len, best, items;
  logic [VAL_W-1:0] best_next, items_next;
  logic             err, last;
  logic             q_issue, u_issue, sweep_wr;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  // size in use saturates at the tree depth
  assign size     = (CW'(seq_len) > MAX_POS) ? MAX_POS : CW'(seq_len);
  assign rank_ext = CW'(item.rank);

  // lowest set bit of each walk position
  assign q_low = qpos & (~qpos + CW'(1));
  assign u_low = upos & (~upos + CW'(1));

  assign q_issue  = cmd.q_step && (qpos != '0);
  assign u_issue  = cmd.u_step && (upos <= size);
  assign sweep_wr = cmd.sweep_step && (sp != '0);

  // chain length for this item, saturating
  assign len = (m == VAL_MAX) ? m : m + VAL_W'(1);

  // counters after this item
  assign best_next  = (!err && (len > best)) ? len : best;
  assign items_next = (!err && (items != VAL_MAX)) ? items + VAL_W'(1) : items;

  // ram port selection
  always_comb begin
    ram_re    = q_issue || u_issue;
    ram_raddr = q_issue ? AW'(qpos - CW'(1)) : AW'(upos - CW'(1));
    ram_we    = 1'b0;
    ram_waddr = upend_addr;
    ram_wdata = (ram_rdata > len) ? ram_rdata : len;
    if (sweep_wr) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(sp - CW'(1));
      ram_wdata = '0;
    end else if (cmd.u_step && upend) begin
      ram_we = 1'b1;
    end
  end

  lfm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_LEN)
  ) u_tree (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // request capture and walk positions
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qpos <= rank_ext - CW'(1);
      upos <= rank_ext;
      err  <= (rank_ext == '0) || (rank_ext > size);
      last <= item.last;
      m    <= '0;
    end else begin
      if (q_issue) begin
        qpos <= qpos - q_low;
      end
      if (cmd.q_step && qpend && (ram_rdata > m)) begin
        m <= ram_rdata;
      end
      if (u_issue) begin
        upos       <= upos + u_low;
        upend_addr <= AW'(upos - CW'(1));
      end
    end
  end

  // walk pending flags, counters, high-water mark and sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      qpend <= 1'b0;
      upend <= 1'b0;
      best  <= '0;
      items <= '0;
      hw    <= '0;
      sp    <= MAX_POS;
    end else begin
      if (cmd.accept) begin
        qpend <= 1'b0;
        upend <= 1'b0;
      end else begin
        if (cmd.q_step) begin
          qpend <= q_issue;
        end
        if (cmd.u_step) begin
          upend <= u_issue;
        end
      end
      if (u_issue && (upos > hw)) begin
        hw <= upos;
      end
      if (cmd.finish) begin
        if (last) begin
          best <= '0;
          items <= '0;
          sp    <= hw;
          hw    <= '0;
        end else begin
          best  <= best_next;
          items <= items_next;
        end
      end else if (sweep_wr) begin
        sp <= sp - CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.best_length <= best_next;
      result.removals    <= (items_next >= best_next) ? items_next - best_next : '0;
      result.range_error <= err;
      result.final_res   <= last;
    end
  end

  // status to the controller
  assign status.bad_rank   = (rank_ext == '0) || (rank_ext > size);
  assign status.q_done     = (qpos == '0) && !qpend;
  assign status.u_done     = (upos > size) && !upend;
  assign status.out_free   = !result_valid || result_ready;
  assign status.last_item  = last;
  assign status.sweep_done = (sp == '0);

endmodule

>>> rtl/core/lis_length_fenwick_max.sv
// Longest increasing subsequence length over a rank stream, Fenwick prefix-max tree.
// An accepted item runs the query walk, then the update walk, then loads the result;
// an out-of-range rank goes straight to the result.
// One item in flight; the next is accepted once the result is loaded (after the sweep for a last item), and
// a result still waiting in the output register holds the block until it is taken.
// After a last item the tree is swept clear from the highest written position down.
// Reset is synchronous; afterwards a clearing sweep over all MAX_LEN positions runs.
`include "lis_length_fenwick_max_macros.svh"
module lis_length_fenwick_max import lfm_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  lfm_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output lfm_result_t result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [VAL_W-1:0] SEQ_LEN_RESET = VAL_W'(1024);

  logic [VAL_W-1:0] seq_len;
  lfm_cmd_t         cmd;
  lfm_status_t      status;

  // configuration register, seq_len at address 0
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= SEQ_LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      seq_len <= pwdata[VAL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(32 - VAL_W){1'b0}}, seq_len};

  lfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfm_dp #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .seq_len     (seq_len),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result      (result),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

  // one request in flight: no ready right after an accept
  `LFM_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready, "item accepted while busy")

  // a result is only loaded when the output register is free
  `LFM_ASSERT_SAME(a_finish_free, cmd.finish, !result_valid || result_ready, "result overwritten")

  // at most one command per cycle
  `LFM_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "conflicting controller commands")

endmodule
